FILE: hdl/lru_key_value_cache_top_assert.svh
// Assertion macros shared by the cache RTL.
// No dependencies; included by the files that carry assertions.
`ifndef LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH

// Property that must hold at every edge out of reset.
`define LKVC_ASSERT_NOW(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define LKVC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define LKVC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
// No dependencies.
package lkvc_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_SET = 1'b0;
    localparam logic CMD_GET = 1'b1;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_TOUCH,
        UPD_INSERT
    } t_upd_mode;

    typedef struct packed {
        t_upd_mode mode;
        logic      is_set;
        logic      evicting;
    } t_row_ctl;

endpackage

FILE: hdl/lkvc_req_if.sv
// Request and response channel interfaces.
// Depends on lkvc_pkg.
interface lkvc_req_if import lkvc_pkg::*; ;
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output command, output key, output value, input ready);
    modport sink   (input valid, input command, input key, input value, output ready);
endinterface

interface lkvc_rsp_if import lkvc_pkg::*; ;
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

FILE: hdl/lkvc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lkvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

FILE: hdl/lkvc_row_unit.sv
// Per-row compare and recency update, shared by the scan and update sweeps.
// Depends on lkvc_pkg.
module lkvc_row_unit import lkvc_pkg::*; #(
    parameter int AW = 4,
    parameter int CW = 5
) (
    input  t_row_ctl          i_ctl,
    input  logic              i_valid,
    input  logic [AW-1:0]     i_idx,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [VAL_W-1:0]  i_value,
    input  logic [AW-1:0]     i_age,
    input  logic [KEY_W-1:0]  i_req_key,
    input  logic [VAL_W-1:0]  i_req_value,
    input  logic [AW-1:0]     i_fidx,
    input  logic [AW-1:0]     i_fage,
    input  logic [AW-1:0]     i_slot,
    input  logic [CW-1:0]     i_capm1,
    output logic              o_match,
    output logic              o_free,
    output logic              o_we,
    output logic              o_valid,
    output logic [KEY_W-1:0]  o_key,
    output logic [VAL_W-1:0]  o_value,
    output logic [AW-1:0]     o_age
);

    logic stale;

    assign o_match = i_valid && (i_key == i_req_key);
    assign stale   = i_valid && i_ctl.evicting && (CW'(i_age) >= i_capm1);
    assign o_free  = !i_valid || stale;

    always_comb begin
        o_we    = 1'b0;
        o_valid = i_valid;
        o_key   = i_key;
        o_value = i_value;
        o_age   = i_age;
        case (i_ctl.mode)
            UPD_TOUCH: begin
                o_we = i_valid;
                if (i_idx == i_fidx) begin
                    o_age = '0;
                    if (i_ctl.is_set) begin
                        o_value = i_req_value;
                    end
                end else if (i_age < i_fage) begin
                    o_age = i_age + AW'(1);
                end
            end
            UPD_INSERT: begin
                if (i_idx == i_slot) begin
                    o_we    = 1'b1;
                    o_valid = 1'b1;
                    o_key   = i_req_key;
                    o_value = i_req_value;
                    o_age   = '0;
                end else if (stale) begin
                    o_valid = 1'b0;
                end else if (i_valid) begin
                    o_we  = 1'b1;
                    o_age = i_age + AW'(1);
                end
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

endmodule

FILE: hdl/lru_key_value_cache_top.sv
// Top level of the LRU key-value cache: sequencer, valid flags, row RAM.
// Depends on lkvc_pkg, lkvc_req_if/lkvc_rsp_if, lkvc_ram, lkvc_row_unit.
//
//  channel   dir  handshake          payload
//  i_req     in   valid/ready        command, key, value
//  o_rsp     out  valid/ready        hit, read_value
//  i_cfg     in   i_cfg_we           i_cfg_wdata (capacity)
//
// One item: a scan sweep through the row RAM read port, then (unless a get misses)
// an update sweep, then a hand-off through S_DONE back to S_IDLE, where the next is taken.
// Reset clears valid flags, live count and capacity (16) at once; no clearing pass.
// The result waits in an output register; a new beat is taken while it waits, and
// the next result holds the sequencer in S_DONE until the waiting one is taken.
`include "lru_key_value_cache_top_assert.svh"

module lru_key_value_cache_top import lkvc_pkg::*; #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata,
    lkvc_req_if.sink         i_req,
    lkvc_rsp_if.source       o_rsp
);

    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = (CW > CAP_W) ? CW : CAP_W;
    localparam int RW = KEY_W + VAL_W + AW;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPD,
        S_DONE
    } t_state;

    t_state                  r_state;
    t_upd_mode               r_mode;
    logic [CAP_W-1:0]        r_capacity;
    logic [CW-1:0]           r_live;
    logic [MAX_ENTRIES-1:0]  r_valid;
    logic [CW-1:0]           r_issue;
    logic                    r_rvalid;
    logic [AW-1:0]           r_ridx;
    logic                    r_cmd;
    logic [KEY_W-1:0]        r_key;
    logic [VAL_W-1:0]        r_val;
    logic                    r_found;
    logic [AW-1:0]           r_fidx;
    logic [AW-1:0]           r_fage;
    logic [VAL_W-1:0]        r_fval;
    logic                    r_has_free;
    logic [AW-1:0]           r_slot;
    logic                    r_rsp_valid;
    logic                    r_rsp_hit;
    logic [VAL_W-1:0]        r_rsp_value;

    logic [EW-1:0]           cap_ext;
    logic [CW-1:0]           cap_eff;
    logic [CW-1:0]           capm1;
    logic                    evicting;
    logic                    issuing;
    logic                    pass_end;
    logic [RW-1:0]           rd_row;
    logic [RW-1:0]           wr_row;
    t_row_ctl                row_ctl;
    logic                    row_match;
    logic                    row_free;
    logic                    row_we;
    logic                    row_valid;
    logic [KEY_W-1:0]        row_key;
    logic [VAL_W-1:0]        row_value;
    logic [AW-1:0]           row_age;
    logic                    live_agrees;
    logic                    rsp_miss;
    logic                    req_beat;
    logic                    scan_fresh;

    always_comb begin
        cap_ext = EW'(r_capacity);
        if (cap_ext == '0) begin
            cap_ext = EW'(1);
        end else if (cap_ext > EW'(MAX_ENTRIES)) begin
            cap_ext = EW'(MAX_ENTRIES);
        end
        cap_eff = CW'(cap_ext);
    end

    assign capm1    = cap_eff - CW'(1);
    assign evicting = (r_live >= cap_eff);
    assign issuing  = (r_issue < CW'(MAX_ENTRIES));
    assign pass_end = !issuing && !r_rvalid;

    assign row_ctl.mode     = (r_state == S_UPD) ? r_mode : UPD_NONE;
    assign row_ctl.is_set   = (r_cmd == CMD_SET);
    assign row_ctl.evicting = evicting;

    lkvc_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_ENTRIES)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (r_rvalid && row_we),
        .i_waddr (r_ridx),
        .i_wdata (wr_row),
        .i_raddr (r_issue[AW-1:0]),
        .o_rdata (rd_row)
    );

    lkvc_row_unit #(
        .AW (AW),
        .CW (CW)
    ) u_row (
        .i_ctl       (row_ctl),
        .i_valid     (r_valid[r_ridx]),
        .i_idx       (r_ridx),
        .i_key       (rd_row[RW-1 -: KEY_W]),
        .i_value     (rd_row[AW +: VAL_W]),
        .i_age       (rd_row[AW-1:0]),
        .i_req_key   (r_key),
        .i_req_value (r_val),
        .i_fidx      (r_fidx),
        .i_fage      (r_fage),
        .i_slot      (r_slot),
        .i_capm1     (capm1),
        .o_match     (row_match),
        .o_free      (row_free),
        .o_we        (row_we),
        .o_valid     (row_valid),
        .o_key       (row_key),
        .o_value     (row_value),
        .o_age       (row_age)
    );

    assign wr_row = {row_key, row_value, row_age};

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.hit        = r_rsp_hit;
    assign o_rsp.read_value = r_rsp_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= UPD_NONE;
            r_capacity  <= CAP_RESET;
            r_live      <= '0;
            r_valid     <= '0;
            r_issue     <= '0;
            r_rvalid    <= 1'b0;
            r_found     <= 1'b0;
            r_has_free  <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (o_rsp.ready && (r_state != S_DONE)) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_cmd      <= i_req.command;
                        r_key      <= i_req.key;
                        r_val      <= i_req.value;
                        r_found    <= 1'b0;
                        r_has_free <= 1'b0;
                        r_issue    <= '0;
                        r_rvalid   <= 1'b0;
                        r_mode     <= UPD_NONE;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN, S_UPD: begin
                    r_rvalid <= issuing;
                    r_ridx   <= r_issue[AW-1:0];
                    if (issuing) begin
                        r_issue <= r_issue + CW'(1);
                    end
                    if (r_rvalid && (r_state == S_SCAN)) begin
                        if (row_match && !r_found) begin
                            r_found <= 1'b1;
                            r_fidx  <= r_ridx;
                            r_fage  <= rd_row[AW-1:0];
                            r_fval  <= rd_row[AW +: VAL_W];
                        end
                        if (row_free && !r_has_free) begin
                            r_has_free <= 1'b1;
                            r_slot     <= r_ridx;
                        end
                    end
                    if (r_rvalid && (r_state == S_UPD)) begin
                        r_valid[r_ridx] <= row_valid;
                    end
                    if (pass_end) begin
                        r_issue <= '0;
                        if (r_state == S_SCAN) begin
                            if (r_found) begin
                                r_mode  <= UPD_TOUCH;
                                r_state <= S_UPD;
                            end else if (r_cmd == CMD_SET) begin
                                r_mode  <= UPD_INSERT;
                                r_state <= S_UPD;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end else begin
                            if (r_mode == UPD_INSERT) begin
                                r_live <= (evicting ? capm1 : r_live) + CW'(1);
                            end
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_rsp_valid || o_rsp.ready) begin
                        r_rsp_valid <= 1'b1;
                        r_rsp_hit   <= r_found;
                        r_rsp_value <= (r_found && (r_cmd == CMD_GET)) ? r_fval : '0;
                        r_mode      <= UPD_NONE;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign live_agrees = (r_state != S_IDLE) || (CW'($countones(r_valid)) == r_live);
    assign rsp_miss    = o_rsp.valid && !o_rsp.hit;
    assign req_beat    = i_req.valid && i_req.ready;
    assign scan_fresh  = (r_state == S_SCAN) && (r_issue == '0);

    `LKVC_ASSERT_NOW(a_live_sync, i_clk, i_rst_n, live_agrees, "live count off")
    `LKVC_ASSERT_NOW(a_live_max, i_clk, i_rst_n, r_live <= CW'(MAX_ENTRIES), "live too high")
    `LKVC_ASSERT_IMPLY(a_miss_zero, i_clk, i_rst_n, rsp_miss, ~|o_rsp.read_value, "miss value")
    `LKVC_ASSERT_NEXT(a_accept_scan, i_clk, i_rst_n, req_beat, scan_fresh, "scan not started")
    `LKVC_ASSERT_IMPLY(a_upd_mode, i_clk, i_rst_n, r_state == S_UPD, r_mode != UPD_NONE, "no mode")

endmodule

FILE: tb/tb_lru_key_value_cache_top.sv
// Self-checking testbench for lru_key_value_cache_top: drives set/get beats, predicts
// every response with its own LRU store model, and checks hit and read_value per beat.
// Depends on lkvc_pkg, lkvc_req_if, lkvc_rsp_if and the cache RTL.
module tb_lru_key_value_cache_top import lkvc_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS       = 16;
    localparam int DRAIN       = 2 * SLOTS + 8;
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 300000;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_req_beat;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] read_value;
    } t_rsp_beat;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_wdata;

    lkvc_req_if req_ch ();
    lkvc_rsp_if rsp_ch ();

    lru_key_value_cache_top #(.MAX_ENTRIES(SLOTS)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch.sink),
        .o_rsp       (rsp_ch.source)
    );

    // LRU store model
    logic             cache_valid [SLOTS];
    logic [KEY_W-1:0] cache_key   [SLOTS];
    logic [VAL_W-1:0] cache_val   [SLOTS];
    int unsigned      cache_rank  [SLOTS];
    int unsigned      cache_live;
    logic [CAP_W-1:0] cache_cap;

    t_req_beat pending_reqs [$];
    t_rsp_beat expected_rsps [$];
    t_req_beat req_in_flight;

    bit          req_busy;
    bit          req_taken;
    bit          idle_on;
    bit          hold_ask;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned cycles;
    int unsigned errors;
    int unsigned set_beats;
    int unsigned get_beats;
    int unsigned hit_beats;
    int unsigned rsp_beats;
    int unsigned cap_writes;

    function automatic void promote_slot(int s);
        int unsigned a;
        a = cache_rank[s];
        for (int i = 0; i < SLOTS; i++)
            if (cache_valid[i] && cache_rank[i] < a) cache_rank[i]++;
        cache_rank[s] = 0;
    endfunction

    function automatic t_rsp_beat apply_request(t_req_beat b);
        int          found;
        int          best;
        int          slot;
        int unsigned eff;
        t_rsp_beat   r;
        found = -1;
        for (int i = 0; i < SLOTS; i++)
            if (found < 0 && cache_valid[i] && cache_key[i] == b.key) found = i;
        r.hit        = (found >= 0);
        r.read_value = '0;
        if (b.command == CMD_SET) begin
            if (found >= 0) begin
                cache_val[found] = b.value;
                promote_slot(found);
            end else begin
                eff = (cache_cap == 0) ? 1 : ((cache_cap > SLOTS) ? SLOTS : cache_cap);
                while (cache_live >= eff && cache_live > 0) begin
                    best = -1;
                    for (int i = 0; i < SLOTS; i++)
                        if (cache_valid[i] && (best < 0 || cache_rank[i] > cache_rank[best]))
                            best = i;
                    cache_valid[best] = 1'b0;
                    cache_rank[best]  = 0;
                    cache_live--;
                end
                slot = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (cache_valid[i]) cache_rank[i]++;
                    else if (slot < 0) slot = i;
                end
                cache_valid[slot] = 1'b1;
                cache_key[slot]   = b.key;
                cache_val[slot]   = b.value;
                cache_rank[slot]  = 0;
                cache_live++;
            end
        end else if (found >= 0) begin
            r.read_value = cache_val[found];
            promote_slot(found);
        end
        return r;
    endfunction

    task automatic push_item(logic cmd, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        t_req_beat b;
        b.command = cmd;
        b.key     = k;
        b.value   = v;
        pending_reqs.push_back(b);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] c);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= c;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= CAP_W'($urandom);
        cache_cap = c;
        cap_writes++;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() != 0 || req_busy || expected_rsps.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    // Random beats over a small key pool so hits, refreshes and evictions all occur
    task automatic push_random(int n, int unsigned cap);
        logic [KEY_W-1:0] pool [$];
        logic [KEY_W-1:0] k;
        int unsigned      eff;
        int unsigned      pick;
        eff = (cap == 0) ? 1 : ((cap > SLOTS) ? SLOTS : cap);
        repeat (eff + $urandom_range(0, 4)) begin
            case ($urandom_range(0, 11))
                0:       k = 32'h8000_0000;
                1:       k = 32'h7FFF_FFFF;
                2:       k = 32'hFFFF_FFFF;
                3:       k = 32'h0000_0000;
                default: k = $urandom;
            endcase
            pool.push_back(k);
        end
        repeat (n) begin
            pick = $urandom_range(0, 9);
            k    = pool[$urandom_range(0, pool.size() - 1)];
            if (pick == 0)      push_item(logic'($urandom_range(0, 1)), $urandom, $urandom);
            else if (pick <= 5) push_item(CMD_SET, k, $urandom);
            else                push_item(CMD_GET, k, $urandom);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Timeout after %0d cycles, %0d responses outstanding",
                     cycles, expected_rsps.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_busy  = 1'b0;
            req_taken = 1'b0;
            gap_left  = 0;
        end else begin
            if (req_taken) begin
                req_taken = 1'b0;
                req_busy  = 1'b0;
                if (idle_on && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 5);
            end
            if (!req_busy) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_reqs.size() > 0) begin
                    req_in_flight = pending_reqs.pop_front();
                    req_busy      = 1'b1;
                end
                if (req_busy) begin
                    req_ch.command <= req_in_flight.command;
                    req_ch.key     <= req_in_flight.key;
                    req_ch.value   <= req_in_flight.value;
                end else begin
                    req_ch.command <= 1'($urandom);
                    req_ch.key     <= $urandom;
                    req_ch.value   <= $urandom;
                end
            end
            req_ch.valid <= req_busy;
        end
    end

    // Response receiver; a long hold-off fills the block and stalls its input
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (hold_ask) begin
                hold_ask  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 5);
            end
        end
    end

    // Monitor: predict on each request beat, check each response beat
    always @(posedge i_clk) begin
        t_req_beat b;
        t_rsp_beat exp_rsp;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                b.command = req_ch.command;
                b.key     = req_ch.key;
                b.value   = req_ch.value;
                exp_rsp   = apply_request(b);
                expected_rsps.push_back(exp_rsp);
                if (b.command == CMD_SET) set_beats++;
                else get_beats++;
                if (exp_rsp.hit) hit_beats++;
                req_taken = 1'b1;
            end
            if (rsp_ch.valid && rsp_ch.ready) begin
                rsp_beats++;
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected response beat hit=%0b read_value=%h",
                             $time, rsp_ch.hit, rsp_ch.read_value);
                    errors++;
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (rsp_ch.hit !== exp_rsp.hit || rsp_ch.read_value !== exp_rsp.read_value)
                    begin
                        $display("%0t: expected hit=%0b value=%h, actual hit=%0b value=%h",
                                 $time, exp_rsp.hit, exp_rsp.read_value,
                                 rsp_ch.hit, rsp_ch.read_value);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        logic [CAP_W-1:0] caps [10];
        caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd3, 5'd8, 5'd2, 5'd12, 5'd16};
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_wdata    = '0;
        idle_on        = 1'b1;
        hold_ask       = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            cache_valid[i] = 1'b0;
            cache_key[i]   = '0;
            cache_val[i]   = '0;
            cache_rank[i]  = 0;
        end
        cache_live = 0;
        cache_cap  = CAP_RESET;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // Extremes at the reset capacity
        push_item(CMD_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        push_item(CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        push_item(CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        push_item(CMD_SET, 32'h0000_0000, 32'h0000_0000);
        push_item(CMD_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_item(CMD_GET, 32'h8000_0000, 32'h0000_0000);
        push_item(CMD_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        push_item(CMD_GET, 32'h0000_0000, 32'h1234_5678);
        push_item(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        push_item(CMD_SET, 32'h8000_0000, 32'h5A5A_A5A5);
        push_item(CMD_GET, 32'h8000_0000, 32'h0000_0000);
        push_item(CMD_GET, 32'h0000_0001, 32'h0000_0000);
        wait_drained();

        // Capacity lowered below the live count: next insert evicts down
        for (int i = 1; i <= 8; i++) push_item(CMD_SET, i, 32'h1000_0000 + i);
        wait_drained();
        write_capacity(5'd2);
        push_item(CMD_GET, 32'd3, 32'h0);
        push_item(CMD_SET, 32'd100, 32'hCAFE_0100);
        push_item(CMD_GET, 32'd1, 32'h0);
        push_item(CMD_GET, 32'd3, 32'h0);
        push_item(CMD_GET, 32'd100, 32'h0);
        push_item(CMD_SET, 32'd101, 32'hCAFE_0101);
        push_item(CMD_GET, 32'd3, 32'h0);
        wait_drained();

        for (int p = 0; p < 10; p++) begin
            write_capacity(caps[p]);
            if (p == 9) idle_on = 1'b0;
            push_random(55, caps[p]);
            if (p == 3) hold_ask = 1'b1;
            wait_drained();
        end

        $display("Covered %0d request beats (%0d sets, %0d gets, %0d hits) and %0d responses",
                 set_beats + get_beats, set_beats, get_beats, hit_beats, rsp_beats);
        $display("over %0d capacity writes incl. 0, 1, 16 and 31, with a long response hold-off",
                 cap_writes);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule
